// ===== rtl/tag_read_qualifier_top_defines.svh =====
// Assertion macros used by the tag read qualifier core (trq_core).
`ifndef TAG_READ_QUALIFIER_TOP_DEFINES_SVH
`define TAG_READ_QUALIFIER_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during rst.
`define TRQ_ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("tag read qualifier: assertion failed");

// Next-cycle implication, clocked on clk, off during rst.
`define TRQ_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("tag read qualifier: assertion failed");

`endif

// ===== rtl/trq_pkg.sv =====
// Types and constants of the tag read qualifier.
package trq_pkg;

  // Field widths
  localparam int KindW       = 2;
  localparam int TimeW       = 32;
  localparam int LenW        = 3;
  localparam int UidW        = 56;
  localparam int IdW         = 16;
  localparam int StatusW     = 3;
  localparam int FailW       = 8;
  localparam int IntervalW   = 16;
  localparam int MaxUidBytes = 7;

  // Stream and config port widths
  localparam int InTdataW  = 96;
  localparam int InUserW   = KindW;
  localparam int OutTdataW = 24;
  localparam int OutUserW  = 1 + StatusW;
  localparam int CfgIndexW = 8;
  localparam int CfgDataW  = 16;

  // Item kinds
  localparam logic [KindW-1:0] KIND_POLL  = 2'd0;
  localparam logic [KindW-1:0] KIND_RESET = 2'd1;
  localparam logic [KindW-1:0] KIND_INIT  = 2'd2;

  // Result status codes
  localparam logic [StatusW-1:0] ST_NEW   = 3'd0;
  localparam logic [StatusW-1:0] ST_RATE  = 3'd1;
  localparam logic [StatusW-1:0] ST_DUP   = 3'd2;
  localparam logic [StatusW-1:0] ST_FAIL  = 3'd3;
  localparam logic [StatusW-1:0] ST_LIMIT = 3'd4;
  localparam logic [StatusW-1:0] ST_INIT  = 3'd5;
  localparam logic [StatusW-1:0] ST_WAIT  = 3'd6;
  localparam logic [StatusW-1:0] ST_RESET = 3'd7;

  // Register indexes
  localparam logic [CfgIndexW-1:0] REG_READ_INTERVAL  = 8'd0;
  localparam logic [CfgIndexW-1:0] REG_REPEAT_GUARD   = 8'd1;
  localparam logic [CfgIndexW-1:0] REG_RETRY_INTERVAL = 8'd2;
  localparam logic [CfgIndexW-1:0] REG_FAIL_LIMIT     = 8'd3;

  // Register reset values
  localparam logic [IntervalW-1:0] READ_INTERVAL_RST  = 16'd100;
  localparam logic [IntervalW-1:0] REPEAT_GUARD_RST   = 16'd2000;
  localparam logic [IntervalW-1:0] RETRY_INTERVAL_RST = 16'd2000;
  localparam logic [FailW-1:0]     FAIL_LIMIT_RST     = 8'd20;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [TimeW-1:0] now_ms;
    logic             init_found;
    logic             read_ok;
    logic [LenW-1:0]  uid_len;
    logic [UidW-1:0]  uid_bytes;
  } item_t;

  typedef struct packed {
    logic [IdW-1:0]     tag_id;
    logic               tag_valid;
    logic [StatusW-1:0] status;
    logic               init_attempted;
    logic               ready_now;
  } result_t;

endpackage

// ===== rtl/tag_read_qualifier_top.sv =====
// Top level of the tag read qualifier.
// Takes one reader event per word (poll, forced reset, direct init) and returns exactly one
// result word for each: a checkpoint ID with its valid flag, a status code and the ready
// flag. An accepted word waits in the input register until the result register has room; its
// result is then registered there and shown on m_tdata/m_tuser (input register, then result
// register). A new word can be taken every cycle; the only stall comes from m_tready held low.
// State updates happen as a word moves from the input register to the result register, so the
// next word always sees the effect of the previous one. The configuration port is always
// ready; writes to indexes beyond the four registers are ignored. No clearing pass follows
// reset.
module tag_read_qualifier_top
  import trq_pkg::*;
#(
  parameter int UID_BYTES = 7
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [InTdataW-1:0]  s_tdata,   // now_ms, init_found, read_ok, uid_len, uid_bytes
  input  logic [InUserW-1:0]   s_tuser,   // kind
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OutTdataW-1:0] m_tdata,   // tag_id, init_attempted, ready_now
  output logic [OutUserW-1:0]  m_tuser,   // tag_valid, status
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data
);

  item_t   item;
  result_t result;
  logic    item_valid;
  logic    out_free;
  logic    advance;

  // Move a word forward when the result register has room
  assign advance   = item_valid && out_free;
  assign cfg_ready = 1'b1;

  trq_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  trq_core #(
    .UID_BYTES (UID_BYTES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (advance),
    .item      (item),
    .result    (result)
  );

  trq_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (advance),
    .result   (result),
    .out_free (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// ===== rtl/trq_in_reg.sv =====
// Input register: holds one incoming word until the core takes it.
module trq_in_reg
  import trq_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [InTdataW-1:0] s_tdata,  // now_ms, init_found, read_ok, uid_len, uid_bytes, pad
  input  logic [InUserW-1:0]  s_tuser,  // kind
  input  logic                advance,
  output logic                item_valid,
  output item_t               item
);

  // Take a word when empty or when the held one moves on this cycle
  assign s_tready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  // Unpack the word
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.kind       <= s_tuser;
      item.now_ms     <= s_tdata[TimeW-1:0];
      item.init_found <= s_tdata[TimeW];
      item.read_ok    <= s_tdata[TimeW+1];
      item.uid_len    <= s_tdata[TimeW+2 +: LenW];
      item.uid_bytes  <= s_tdata[TimeW+2+LenW +: UidW];
    end
  end

endmodule

// ===== rtl/trq_core.sv =====
// Decision logic and reader state of the tag read qualifier.
`include "tag_read_qualifier_top_defines.svh"

module trq_core
  import trq_pkg::*;
#(
  parameter int UID_BYTES = 7
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data,
  input  logic                 fire,
  input  item_t                item,
  output result_t              result
);

  localparam int UidKeep = (UID_BYTES < MaxUidBytes) ? UID_BYTES : MaxUidBytes;
  localparam logic [LenW-1:0] LenMax = LenW'(UidKeep);

  // Configuration registers
  logic [IntervalW-1:0] read_interval_ms;
  logic [IntervalW-1:0] repeat_guard_ms;
  logic [IntervalW-1:0] retry_interval_ms;
  logic [FailW-1:0]     fail_limit;

  // Reader state
  logic                 ready;
  logic [TimeW-1:0]     last_poll_time;
  logic [TimeW-1:0]     last_retry_time;
  logic [FailW-1:0]     fail_count;
  logic [UidKeep*8-1:0] prev_uid;
  logic [LenW-1:0]      prev_uid_len;
  logic [TimeW-1:0]     prev_uid_time;

  logic                 ready_next;
  logic                 upd_poll;
  logic                 upd_retry;
  logic                 upd_uid;
  logic [FailW-1:0]     fail_count_next;

  logic [LenW-1:0]      len;
  logic [7:0][7:0]      uid_b;
  logic [UidKeep*8-1:0] uid_cur;
  logic [LenW-1:0]      idx_hi;
  logic [LenW-1:0]      idx_lo;
  logic [IdW-1:0]       id_calc;
  logic [FailW-1:0]     fail_inc;
  logic                 retry_wait;
  logic                 rate_wait;
  logic                 guard_hit;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      read_interval_ms  <= READ_INTERVAL_RST;
      repeat_guard_ms   <= REPEAT_GUARD_RST;
      retry_interval_ms <= RETRY_INTERVAL_RST;
      fail_limit        <= FAIL_LIMIT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_READ_INTERVAL:  read_interval_ms  <= cfg_data;
        REG_REPEAT_GUARD:   repeat_guard_ms   <= cfg_data;
        REG_RETRY_INTERVAL: retry_interval_ms <= cfg_data;
        REG_FAIL_LIMIT:     fail_limit        <= cfg_data[FailW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp length and mask unused UID bytes
  assign len = (item.uid_len > LenMax) ? LenMax : item.uid_len;

  always_comb begin
    uid_b = '0;
    for (int i = 0; i < UidKeep; i++) begin
      if (LenW'(i) < len) begin
        uid_b[i] = item.uid_bytes[i*8 +: 8];
      end
    end
  end

  assign uid_cur = uid_b[UidKeep-1:0];

  // Checkpoint ID from the last two bytes, or the single byte
  assign idx_hi = len - LenW'(2);
  assign idx_lo = len - LenW'(1);

  always_comb begin
    if (len >= LenW'(2)) begin
      id_calc = {uid_b[idx_hi], uid_b[idx_lo]};
    end else if (len == LenW'(1)) begin
      id_calc = {8'h00, uid_b[0]};
    end else begin
      id_calc = '0;
    end
  end

  // Elapsed-time checks, wrapping modulo 2^32
  assign retry_wait = (item.now_ms - last_retry_time) < {16'h0000, retry_interval_ms};
  assign rate_wait  = (item.now_ms - last_poll_time) < {16'h0000, read_interval_ms};
  assign guard_hit  = (len == prev_uid_len) && (uid_cur == prev_uid) &&
                      ((item.now_ms - prev_uid_time) < {16'h0000, repeat_guard_ms});
  assign fail_inc   = fail_count + FailW'(1);

  // Classify the item and work out the state update
  always_comb begin
    result          = '0;
    result.status   = ST_WAIT;
    ready_next      = ready;
    fail_count_next = fail_count;
    upd_poll        = 1'b0;
    upd_retry       = 1'b0;
    upd_uid         = 1'b0;
    case (item.kind)
      KIND_RESET: begin
        ready_next    = 1'b0;
        result.status = ST_RESET;
      end
      KIND_INIT: begin
        ready_next            = item.init_found;
        result.init_attempted = 1'b1;
        result.status         = ST_INIT;
      end
      KIND_POLL: begin
        if (!ready) begin
          if (!retry_wait) begin
            upd_retry             = 1'b1;
            ready_next            = item.init_found;
            result.init_attempted = 1'b1;
            result.status         = ST_INIT;
          end
        end else if (rate_wait) begin
          result.status = ST_RATE;
        end else begin
          upd_poll = 1'b1;
          if (!item.read_ok) begin
            if (fail_inc >= fail_limit) begin
              fail_count_next = '0;
              ready_next      = 1'b0;
              result.status   = ST_LIMIT;
            end else begin
              fail_count_next = fail_inc;
              result.status   = ST_FAIL;
            end
          end else begin
            fail_count_next = '0;
            if (guard_hit) begin
              result.status = ST_DUP;
            end else begin
              upd_uid          = 1'b1;
              result.tag_id    = id_calc;
              result.tag_valid = 1'b1;
              result.status    = ST_NEW;
            end
          end
        end
      end
      default: ;
    endcase
    result.ready_now = ready_next;
  end

  // Advance state when the item moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      ready           <= 1'b0;
      last_poll_time  <= '0;
      last_retry_time <= '0;
      fail_count      <= '0;
      prev_uid        <= '0;
      prev_uid_len    <= '0;
      prev_uid_time   <= '0;
    end else if (fire) begin
      ready      <= ready_next;
      fail_count <= fail_count_next;
      if (upd_poll) begin
        last_poll_time <= item.now_ms;
      end
      if (upd_retry) begin
        last_retry_time <= item.now_ms;
      end
      if (upd_uid) begin
        prev_uid      <= uid_cur;
        prev_uid_len  <= len;
        prev_uid_time <= item.now_ms;
      end
    end
  end

  `TRQ_ASSERT_IMPL(a_valid_only_new, result.tag_valid, result.status == ST_NEW)
  `TRQ_ASSERT_IMPL(a_id_zero_unless_valid, !result.tag_valid, result.tag_id == '0)
  `TRQ_ASSERT_NEXT(a_reset_drops_ready, fire && item.kind == KIND_RESET, !ready)
  `TRQ_ASSERT_NEXT(a_limit_clears, fire && result.status == ST_LIMIT, !ready && fail_count == '0)

endmodule

// ===== rtl/trq_out_reg.sv =====
// Result register: holds one result word until the consumer takes it.
module trq_out_reg
  import trq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  result_t              result,
  output logic                 out_free,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OutTdataW-1:0] m_tdata,  // tag_id, init_attempted, ready_now, pad
  output logic [OutUserW-1:0]  m_tuser   // tag_valid, status
);

  result_t held;

  // Free when empty or when the held word leaves this cycle
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  // Pack the word
  assign m_tdata = {6'b000000, held.ready_now, held.init_attempted, held.tag_id};
  assign m_tuser = {held.status, held.tag_valid};

endmodule

// ===== tb/tb_tag_read_qualifier_top.sv =====
// Self-checking testbench for the tag read qualifier: directed table, random phases, scoreboard.
`timescale 1ns / 1ps

module tb_tag_read_qualifier_top;
  import trq_pkg::*;

  localparam int UidBytes   = 7;
  localparam int CycleLimit = 400000;
  localparam int NumDir     = 20;
  localparam int PhaseWords = 280;

  // Kind code the block leaves unused, and a register index past the last one
  localparam logic [KindW-1:0]     KIND_SPARE = 2'd3;
  localparam logic [CfgIndexW-1:0] REG_UNUSED = 8'd4;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [InTdataW-1:0]  s_tdata = '0;   // now_ms, init_found, read_ok, uid_len, uid_bytes
  logic [InUserW-1:0]   s_tuser = '0;   // kind
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OutTdataW-1:0] m_tdata;        // tag_id, init_attempted, ready_now
  logic [OutUserW-1:0]  m_tuser;        // tag_valid, status
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_data = '0;

  tag_read_qualifier_top #(
    .UID_BYTES(UidBytes)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Clock: 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Qualifier state mirrored for prediction
  logic [IntervalW-1:0] read_ivl  = READ_INTERVAL_RST;
  logic [IntervalW-1:0] guard_ivl = REPEAT_GUARD_RST;
  logic [IntervalW-1:0] retry_ivl = RETRY_INTERVAL_RST;
  logic [FailW-1:0]     fail_lim  = FAIL_LIMIT_RST;
  logic                 rdy       = 1'b0;
  logic [TimeW-1:0]     last_poll_ms  = '0;
  logic [TimeW-1:0]     last_retry_ms = '0;
  logic [FailW-1:0]     fail_cnt  = '0;
  logic [UidW-1:0]      prev_uid  = '0;
  logic [LenW-1:0]      prev_len  = '0;
  logic [TimeW-1:0]     prev_uid_ms = '0;

  result_t pending_results[$];
  int      send_idle = 0;
  int      recv_stall = 0;
  int      rx_hold_cycles = 0;
  int      errors = 0;
  int      words_sent = 0;
  int      results_seen = 0;
  int      cfg_writes = 0;
  int      cycle_count = 0;
  int      status_count[8];

  // Stimulus timeline and last UID handed out, reused to provoke duplicates
  logic [TimeW-1:0] stim_ms = '0;
  logic [UidW-1:0]  stim_uid = '0;
  logic [LenW-1:0]  stim_len = '0;

  function automatic logic [UidW-1:0] uid_mask(int n);
    logic [63:0] m;
    m = (64'd1 << (8 * n)) - 64'd1;
    return m[UidW-1:0];
  endfunction

  // Work out the result of one word and advance the mirrored state
  function automatic result_t qualify_word(item_t w);
    result_t          r;
    int               n;
    logic [UidW-1:0]  uid;
    logic [TimeW-1:0] dt;
    r = '0;
    r.status = ST_WAIT;
    n = int'(w.uid_len);
    if (n > UidBytes) n = UidBytes;
    if (n > MaxUidBytes) n = MaxUidBytes;
    uid = w.uid_bytes & uid_mask(n);
    case (w.kind)
      KIND_RESET: begin
        rdy = 1'b0;
        r.status = ST_RESET;
      end
      KIND_INIT: begin
        rdy = w.init_found;
        r.init_attempted = 1'b1;
        r.status = ST_INIT;
      end
      KIND_POLL: begin
        if (!rdy) begin
          dt = w.now_ms - last_retry_ms;
          if (dt >= {16'd0, retry_ivl}) begin
            last_retry_ms = w.now_ms;
            rdy = w.init_found;
            r.init_attempted = 1'b1;
            r.status = ST_INIT;
          end
        end else begin
          dt = w.now_ms - last_poll_ms;
          if (dt < {16'd0, read_ivl}) begin
            r.status = ST_RATE;
          end else if (!w.read_ok) begin
            last_poll_ms = w.now_ms;
            fail_cnt = fail_cnt + 8'd1;
            if (fail_cnt >= fail_lim) begin
              fail_cnt = '0;
              rdy = 1'b0;
              r.status = ST_LIMIT;
            end else begin
              r.status = ST_FAIL;
            end
          end else begin
            last_poll_ms = w.now_ms;
            fail_cnt = '0;
            dt = w.now_ms - prev_uid_ms;
            if (n == prev_len && uid == prev_uid && dt < {16'd0, guard_ivl}) begin
              r.status = ST_DUP;
            end else begin
              prev_uid = uid;
              prev_len = n[LenW-1:0];
              prev_uid_ms = w.now_ms;
              if (n >= 2) r.tag_id = {uid[(n-2)*8 +: 8], uid[(n-1)*8 +: 8]};
              else if (n == 1) r.tag_id = {8'd0, uid[7:0]};
              r.tag_valid = 1'b1;
              r.status = ST_NEW;
            end
          end
        end
      end
      default: ;
    endcase
    r.ready_now = rdy;
    return r;
  endfunction

  // Offer one word, hold it until taken, then queue its expected result
  task automatic send_word(item_t w, bit typed, result_t typed_res);
    result_t pred;
    while ($urandom_range(99) < send_idle) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tdata  = {3'b000, w.uid_bytes, w.uid_len, w.read_ok, w.init_found, w.now_ms};
    s_tuser  = w.kind;
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    pred = qualify_word(w);
    pending_results.push_back(typed ? typed_res : pred);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic cfg_write(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_READ_INTERVAL:  read_ivl  = val;
      REG_REPEAT_GUARD:   guard_ivl = val;
      REG_RETRY_INTERVAL: retry_ivl = val;
      REG_FAIL_LIMIT:     fail_lim  = val[FailW-1:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Drain: every word sent has its result back
  task automatic wait_idle();
    s_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic set_config(logic [15:0] rd, logic [15:0] guard, logic [15:0] retry,
                            logic [15:0] lim);
    wait_idle();
    cfg_write(REG_READ_INTERVAL, rd);
    cfg_write(REG_REPEAT_GUARD, guard);
    cfg_write(REG_RETRY_INTERVAL, retry);
    cfg_write(REG_FAIL_LIMIT, lim);
  endtask

  // Random words, mostly polls, on a timeline that mostly steps around the configured intervals
  task automatic run_random(int n_words);
    item_t       w;
    int          r;
    logic [63:0] junk;
    logic [UidW-1:0] m;
    stim_ms = $urandom;
    for (int i = 0; i < n_words; i++) begin
      r = $urandom_range(99);
      if (r < 80) w.kind = KIND_POLL;
      else if (r < 87) w.kind = KIND_RESET;
      else if (r < 95) w.kind = KIND_INIT;
      else w.kind = KIND_SPARE;
      r = $urandom_range(99);
      if (r < 40) stim_ms += $urandom_range(150);
      else if (r < 75) stim_ms += $urandom_range(2500);
      else if (r < 95) stim_ms += $urandom_range(70000);
      else stim_ms += $urandom;
      w.now_ms     = stim_ms;
      w.init_found = ($urandom_range(99) < 85);
      w.read_ok    = ($urandom_range(99) < 70);
      junk = {$urandom, $urandom};
      if ($urandom_range(99) < 45) begin
        // same UID again, with fresh bytes above its length
        m = uid_mask(int'(stim_len));
        w.uid_len   = stim_len;
        w.uid_bytes = (stim_uid & m) | (junk[UidW-1:0] & ~m);
      end else begin
        w.uid_len   = LenW'($urandom_range(7));
        w.uid_bytes = junk[UidW-1:0];
      end
      stim_len = w.uid_len;
      stim_uid = w.uid_bytes;
      send_word(w, 1'b0, '0);
    end
  endtask

  // Directed table: config rows and words, the words with or without a typed-in result
  typedef struct packed {
    bit                   cfg_row;
    logic [CfgIndexW-1:0] reg_idx;
    logic [CfgDataW-1:0]  reg_val;
    item_t                word;
    bit                   typed;
    result_t              res;
  } dir_row_t;

  dir_row_t dir_rows [NumDir] = '{
    // not ready right after reset: retry window still closed
    '{1'b0, 8'd0, 16'd0, '{KIND_POLL, 32'd0, 1'b1, 1'b0, 3'd0, 56'd0},
      1'b1, '{16'h0, 1'b0, ST_WAIT, 1'b0, 1'b0}},
    '{1'b0, 8'd0, 16'd0, '{KIND_POLL, 32'd2000, 1'b0, 1'b0, 3'd0, 56'd0},
      1'b1, '{16'h0, 1'b0, ST_INIT, 1'b1, 1'b0}},
    '{1'b0, 8'd0, 16'd0, '{KIND_POLL, 32'd2500, 1'b1, 1'b1, 3'd0, 56'd0},
      1'b1, '{16'h0, 1'b0, ST_WAIT, 1'b0, 1'b0}},
    // unused kind with every field at its maximum
    '{1'b0, 8'd0, 16'd0, '{KIND_SPARE, 32'hFFFF_FFFF, 1'b1, 1'b1, 3'd7, 56'hFF_FFFF_FFFF_FFFF},
      1'b1, '{16'h0, 1'b0, ST_WAIT, 1'b0, 1'b0}},
    // direct init brings the reader up without touching the timers
    '{1'b0, 8'd0, 16'd0, '{KIND_INIT, 32'd0, 1'b1, 1'b0, 3'd0, 56'd0},
      1'b1, '{16'h0, 1'b0, ST_INIT, 1'b1, 1'b1}},
    '{1'b0, 8'd0, 16'd0, '{KIND_POLL, 32'd0, 1'b0, 1'b1, 3'd7, 56'hFF_FFFF_FFFF_FFFF},
      1'b1, '{16'h0, 1'b0, ST_RATE, 1'b0, 1'b1}},
    '{1'b0, 8'd0, 16'd0, '{KIND_POLL, 32'hFFFF_FFFF, 1'b0, 1'b1, 3'd7, 56'hFF_FFFF_FFFF_FFFF},
      1'b1, '{16'hFFFF, 1'b1, ST_NEW, 1'b0, 1'b1}},
    // time wraps; same UID inside the guard
    '{1'b0, 8'd0, 16'd0, '{KIND_POLL, 32'd99, 1'b0, 1'b1, 3'd7, 56'hFF_FFFF_FFFF_FFFF},
      1'b1, '{16'h0, 1'b0, ST_DUP, 1'b0, 1'b1}},
    '{1'b0, 8'd0, 16'd0, '{KIND_POLL, 32'd199, 1'b0, 1'b1, 3'd1, 56'h12_3456_789A_BC5A},
      1'b1, '{16'h005A, 1'b1, ST_NEW, 1'b0, 1'b1}},
    // empty UID is a new tag, then a duplicate
    '{1'b0, 8'd0, 16'd0, '{KIND_POLL, 32'd299, 1'b0, 1'b1, 3'd0, 56'hAB_CDEF_0123_4567},
      1'b1, '{16'h0, 1'b1, ST_NEW, 1'b0, 1'b1}},
    '{1'b0, 8'd0, 16'd0, '{KIND_POLL, 32'd399, 1'b0, 1'b1, 3'd0, 56'h00_0000_0000_0000},
      1'b1, '{16'h0, 1'b0, ST_DUP, 1'b0, 1'b1}},
    '{1'b0, 8'd0, 16'd0, '{KIND_POLL, 32'd499, 1'b0, 1'b0, 3'd2, 56'h00_0000_0000_1234},
      1'b1, '{16'h0, 1'b0, ST_FAIL, 1'b0, 1'b1}},
    '{1'b0, 8'd0, 16'd0, '{KIND_RESET, 32'hFFFF_FFFF, 1'b1, 1'b1, 3'd7, 56'hFF_FFFF_FFFF_FFFF},
      1'b1, '{16'h0, 1'b0, ST_RESET, 1'b0, 1'b0}},
    '{1'b0, 8'd0, 16'd0, '{KIND_INIT, 32'd0, 1'b0, 1'b0, 3'd0, 56'd0},
      1'b1, '{16'h0, 1'b0, ST_INIT, 1'b1, 1'b0}},
    '{1'b0, 8'd0, 16'd0, '{KIND_INIT, 32'd0, 1'b1, 1'b0, 3'd0, 56'd0},
      1'b1, '{16'h0, 1'b0, ST_INIT, 1'b1, 1'b1}},
    '{1'b0, 8'd0, 16'd0, '{KIND_POLL, 32'd600, 1'b0, 1'b1, 3'd2, 56'h00_0000_0000_A5C3},
      1'b1, '{16'hC3A5, 1'b1, ST_NEW, 1'b0, 1'b1}},
    '{1'b0, 8'd0, 16'd0, '{KIND_POLL, 32'd700, 1'b0, 1'b1, 3'd3, 56'hFF_EE00_0011_2233},
      1'b0, '0},
    // zero fail limit: first failed read drops ready
    '{1'b1, REG_FAIL_LIMIT, 16'd0, '0, 1'b0, '0},
    '{1'b0, 8'd0, 16'd0, '{KIND_POLL, 32'd1000, 1'b1, 1'b0, 3'd0, 56'd0},
      1'b1, '{16'h0, 1'b0, ST_LIMIT, 1'b0, 1'b0}},
    '{1'b0, 8'd0, 16'd0, '{KIND_POLL, 32'd1000, 1'b1, 1'b0, 3'd0, 56'd0},
      1'b0, '0}
  };

  task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Receiver: random stalls, or a counted hold-off when one is requested
  always @(negedge clk) begin
    if (rx_hold_cycles > 0) begin
      rx_hold_cycles--;
      m_tready = 1'b0;
    end else begin
      m_tready = ($urandom_range(99) >= recv_stall);
    end
  end

  // Scoreboard: compare each result word with the oldest expectation
  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.tag_id         = m_tdata[15:0];
      got.init_attempted = m_tdata[16];
      got.ready_now      = m_tdata[17];
      got.tag_valid      = m_tuser[0];
      got.status         = m_tuser[3:1];
      results_seen++;
      status_count[got.status]++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t ns: result with nothing expected, actual %h", $time, got);
      end else begin
        want = pending_results.pop_front();
        compare_field("tag_id", want.tag_id, got.tag_id);
        compare_field("tag_valid", want.tag_valid, got.tag_valid);
        compare_field("status", want.status, got.status);
        compare_field("init_attempted", want.init_attempted, got.init_attempted);
        compare_field("ready_now", want.ready_now, got.ready_now);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("%0t ns: timeout, %0d results still expected", $time, pending_results.size());
      $display("FAIL tag_read_qualifier_top");
      $finish;
    end
  end

  initial begin
    foreach (status_count[i]) status_count[i] = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table, starting from reset settings
    for (int i = 0; i < NumDir; i++) begin
      if (dir_rows[i].cfg_row) begin
        wait_idle();
        cfg_write(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].res);
      end
    end

    // Reset settings, no idling
    set_config(16'd100, 16'd2000, 16'd2000, 16'd20);
    run_random(PhaseWords);

    // Lowest settings, sender mostly idle
    send_idle = 82;
    set_config(16'd0, 16'd0, 16'd0, 16'd1);
    run_random(PhaseWords);

    // Highest settings, receiver mostly stalled
    send_idle = 0;
    recv_stall = 82;
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd255);
    run_random(PhaseWords);

    // Mid settings, both sides idle; junk in the fail limit upper byte
    send_idle = 35;
    recv_stall = 35;
    set_config(16'($urandom_range(300)), 16'($urandom_range(3000)),
               16'($urandom_range(3000)), {8'hA5, 8'($urandom_range(1, 8))});
    cfg_write(REG_UNUSED, 16'($urandom));
    run_random(PhaseWords);

    // Zero fail limit; long receiver hold-off backs the block up
    send_idle = 0;
    recv_stall = 0;
    set_config(16'($urandom_range(200)), 16'($urandom_range(2500)),
               16'($urandom_range(2500)), 16'd0);
    rx_hold_cycles = 400;
    run_random(PhaseWords);

    // Random settings, sender mostly idle
    send_idle = 82;
    set_config(16'($urandom_range(500)), 16'($urandom_range(4000)),
               16'($urandom_range(4000)), 16'($urandom_range(1, 6)));
    run_random(PhaseWords);

    wait_idle();
    repeat (10) @(posedge clk);

    $display("Sent %0d words across six settings plus a directed table, %0d config writes,",
             words_sent, cfg_writes);
    $display("checked %0d results: new %0d, skip %0d, dup %0d, fail %0d, limit %0d, init %0d,"
             , results_seen, status_count[ST_NEW], status_count[ST_RATE],
             status_count[ST_DUP], status_count[ST_FAIL], status_count[ST_LIMIT],
             status_count[ST_INIT]);
    if (errors == 0) begin
      $display("PASS tag_read_qualifier_top");
    end else begin
      $display("FAIL tag_read_qualifier_top");
    end
    $finish;
  end

endmodule
